/* hw/rtl/angle_frame_deframer_core_defines.svh */
// ----------------------------------------------------------------------------
// angle frame deframer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ANGLE_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define ANGLE_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define AFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("afd check failed");

// next-cycle implication, disabled while reset is held
`define AFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("afd check failed");

`endif

/* hw/rtl/afd_pkg.sv */
// ----------------------------------------------------------------------------
// afd_pkg
// shared constants and types of the angle frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

    localparam int BYTE_W      = 8;
    localparam int FRAME_LEN   = 8;
    localparam int WIN_DEPTH   = FRAME_LEN - 1;
    localparam int SEEN_W      = 3;
    localparam int FIELD_W     = 6;
    localparam int ANGLE_W     = 3 * FIELD_W;
    localparam int ELEV_W      = ANGLE_W + 1;
    localparam int OUT_DATA_W  = 40;

    localparam logic [SEEN_W-1:0]  SEEN_FULL  = SEEN_W'(WIN_DEPTH);
    localparam logic [BYTE_W-1:0]  HDR_MASK   = 8'h44;
    localparam logic [BYTE_W-1:0]  HDR_VALUE  = 8'h40;
    localparam logic [ANGLE_W-1:0] HALF_TURN  = 18'h20000;
    localparam logic [ANGLE_W-1:0] OFFSET_RST = 18'h08000;

    // candidate frame handed from the window stage to the decode stage
    typedef struct packed {
        logic                              chk;
        logic [FRAME_LEN-1:0][BYTE_W-1:0]  bytes;
    } t_frame;

endpackage

`default_nettype wire

/* hw/rtl/afd_window.sv */
// ----------------------------------------------------------------------------
// afd_window
// sliding byte window per packet and the candidate frame register
// ----------------------------------------------------------------------------
`default_nettype none

module afd_window
    import afd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [BYTE_W-1:0]  i_data_byte,
    input  wire logic               i_packet_start,
    input  wire logic               i_advance,
    output t_frame                  o_frame,
    output logic                    o_frame_vld
);

    logic [WIN_DEPTH-1:0][BYTE_W-1:0] r_win, n_win;
    logic [SEEN_W-1:0]                r_seen, n_seen;
    logic                             r_vld, n_vld;
    t_frame                           r_frame, n_frame;

    logic [WIN_DEPTH-1:0][BYTE_W-1:0] base_win;
    logic [SEEN_W-1:0]                base_seen;

    always_comb begin
        // a new packet starts from an empty window
        base_win  = i_packet_start ? '0 : r_win;
        base_seen = i_packet_start ? '0 : r_seen;

        n_frame.chk   = (base_seen == SEEN_FULL);
        n_frame.bytes = {i_data_byte, base_win};

        n_win  = {i_data_byte, base_win[WIN_DEPTH-1:1]};
        n_seen = (base_seen == SEEN_FULL) ? SEEN_FULL : base_seen + SEEN_W'(1);

        if (i_accept) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end else begin
            n_vld = r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_seen <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_accept) begin
                r_win  <= n_win;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame     = r_frame;
    assign o_frame_vld = r_vld;

endmodule

`default_nettype wire

/* hw/rtl/afd_decode.sv */
// ----------------------------------------------------------------------------
// afd_decode
// frame check, angle assembly and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module afd_decode
    import afd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_frame              i_frame,
    input  wire logic                i_frame_vld,
    input  wire logic [ANGLE_W-1:0]  i_elev_offset,
    input  wire logic                i_out_ready,
    output logic                     o_free,
    output logic                     o_out_vld,
    output logic [ANGLE_W-1:0]       o_bearing,
    output logic [ELEV_W-1:0]        o_elevation
);

    logic                 r_out_vld, n_out_vld;
    logic [ANGLE_W-1:0]   r_bearing, n_bearing;
    logic [ELEV_W-1:0]    r_elev, n_elev;

    logic [BYTE_W-1:0]    xsum;
    logic                 frame_ok;
    logic                 free;
    logic                 load;
    logic [ANGLE_W-1:0]   raw_elev;
    logic [ANGLE_W:0]     elev_sum;
    logic [ANGLE_W-1:0]   elev_wrap;

    always_comb begin
        xsum = i_frame.bytes[0] ^ i_frame.bytes[1] ^ i_frame.bytes[2] ^ i_frame.bytes[3]
             ^ i_frame.bytes[4] ^ i_frame.bytes[5] ^ i_frame.bytes[6];

        frame_ok = i_frame.chk
                && ((i_frame.bytes[0] & HDR_MASK) == HDR_VALUE)
                && (xsum[FIELD_W-1:0] == i_frame.bytes[7][FIELD_W-1:0])
                && i_frame.bytes[7][BYTE_W-1]
                && !i_frame.bytes[6][0];

        n_bearing = {i_frame.bytes[0][FIELD_W-1:0], i_frame.bytes[1][FIELD_W-1:0],
                     i_frame.bytes[2][FIELD_W-1:0]};
        raw_elev  = {i_frame.bytes[3][FIELD_W-1:0], i_frame.bytes[4][FIELD_W-1:0],
                     i_frame.bytes[5][FIELD_W-1:0]};

        // offset mod full turn, then anything past a half turn goes negative
        elev_sum  = {1'b0, raw_elev} + {1'b0, i_elev_offset};
        elev_wrap = elev_sum[ANGLE_W-1:0];
        n_elev    = {(elev_wrap > HALF_TURN), elev_wrap};

        free = !r_out_vld || i_out_ready;
        load = i_frame_vld && free && frame_ok;

        if (load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bearing <= n_bearing;
            r_elev    <= n_elev;
        end
    end

    assign o_free      = free;
    assign o_out_vld   = r_out_vld;
    assign o_bearing   = r_bearing;
    assign o_elevation = r_elev;

endmodule

`default_nettype wire

/* hw/rtl/angle_frame_deframer_core.sv */
// ----------------------------------------------------------------------------
// angle_frame_deframer_core
// finds 8-byte angle frames in a byte stream, emits bearing and elevation
//
// channel   dir   handshake                    payload
// s_axis    in    s_axis_tvalid/s_axis_tready  tdata: data_byte, tuser: packet_start
// m_axis    out   m_axis_tvalid/m_axis_tready  tdata: bearing, elevation
// cfg       in    i_cfg_valid/o_cfg_ready      i_cfg_data: elevation_offset
//
// one byte per cycle while s_axis_tready is high; a byte goes through the
// window register and then the result register before a matching frame
// shows on m_axis. s_axis_tready drops only while the result register is
// full and m_axis_tready is low with a byte waiting in the window stage.
// reset is synchronous, active low; it empties the window and sets the
// elevation offset to 45 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module angle_frame_deframer_core
    import afd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tuser,   // [0] packet_start
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,   // [17:0] bearing, [36:18] elevation
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [ANGLE_W-1:0]     i_cfg_data
);

    logic [ANGLE_W-1:0] r_elev_offset;

    t_frame             frame;
    logic               frame_vld;
    logic               out_free;
    logic               accept;
    logic               advance;
    logic [ANGLE_W-1:0] bearing;
    logic [ELEV_W-1:0]  elevation;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elev_offset <= OFFSET_RST;
        end else if (i_cfg_valid) begin
            r_elev_offset <= i_cfg_data;
        end
    end

    assign advance       = frame_vld && out_free;
    assign s_axis_tready = !frame_vld || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    afd_window u_window (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (s_axis_tdata),
        .i_packet_start (s_axis_tuser),
        .i_advance      (advance),
        .o_frame        (frame),
        .o_frame_vld    (frame_vld)
    );

    afd_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (frame),
        .i_frame_vld    (frame_vld),
        .i_elev_offset  (r_elev_offset),
        .i_out_ready    (m_axis_tready),
        .o_free         (out_free),
        .o_out_vld      (m_axis_tvalid),
        .o_bearing      (bearing),
        .o_elevation    (elevation)
    );

    assign m_axis_tdata = {(OUT_DATA_W - ANGLE_W - ELEV_W)'(0), elevation, bearing};

endmodule

`default_nettype wire

/* hw/rtl/afd_checker.sv */
// ----------------------------------------------------------------------------
// afd_checker
// port-level checks of the angle frame deframer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "angle_frame_deframer_core_defines.svh"

module afd_checker
    import afd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0]  m_axis_tdata    // [17:0] bearing, [36:18] elevation
);

    logic stalled;
    logic elev_ok;
    logic pad_zero;
    logic hdr_bit_clear;

    assign stalled       = m_axis_tvalid && !m_axis_tready;
    // elevation never reads as minus a full turn
    assign elev_ok       = (m_axis_tdata[ANGLE_W+ELEV_W-1:ANGLE_W] != {1'b1, ANGLE_W'(0)});
    assign pad_zero      = (m_axis_tdata[OUT_DATA_W-1:ANGLE_W+ELEV_W] == '0);
    // header mask keeps bit 2 of the first byte clear, bit 14 of the bearing
    assign hdr_bit_clear = !m_axis_tdata[2 * FIELD_W + 2];

    `AFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata))
    `AFD_ASSERT_NOW(a_out_range, i_clk, i_rst_n, m_axis_tvalid, elev_ok && pad_zero)
    `AFD_ASSERT_NOW(a_out_header, i_clk, i_rst_n, m_axis_tvalid, hdr_bit_clear)
    `AFD_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)
    `AFD_ASSERT_NOW(a_rst_empty, i_clk, i_rst_n, $past(!i_rst_n), !m_axis_tvalid)

endmodule

bind angle_frame_deframer_core afd_checker u_afd_checker (.*);

`default_nettype wire
